### rtl/brm_pkg.sv
`timescale 1ns / 1ps
// Package: shared widths, event codes, constants and the job record of the busy ratio monitor.
package brm_pkg;

  localparam int unsigned TIME_W       = 64;
  localparam int unsigned RATIO_W      = 14;
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned S_TDATA_W    = 64;
  localparam int unsigned M_TDATA_W    = 144;

  localparam logic [RATIO_W-1:0] RATIO_FULL = RATIO_W'(10000);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FRAME_START  = 2'd0,
    FUNC_FRAME_END    = 2'd1,
    FUNC_WINDOW_OPEN  = 2'd2,
    FUNC_WINDOW_CLOSE = 2'd3
  } func_e;

  typedef struct packed {
    logic [TIME_W-1:0] busy;
    logic [TIME_W-1:0] window;
  } job_t;

  typedef struct packed {
    logic valid;
    logic ready;
    job_t job;
  } qport_t;

endpackage

### rtl/brm_front.sv
`timescale 1ns / 1ps
// Front end: takes event beats, keeps frame and window state, queues window-close jobs.
module brm_front
  import brm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] in_func_i,
  input  logic [TIME_W-1:0] in_now_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output job_t              push_job_o
);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_SPAN  = 3'b010,
    F_APPLY = 3'b100
  } fstate_e;

  fstate_e           state_q, state_d;
  func_e             func_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] fbt_q, wbt_q, busy_q, span_q, window_q;
  logic              running_q, measuring_q;
  logic [TIME_W-1:0] from_w;
  logic [TIME_W:0]   sum_w;
  logic [TIME_W-1:0] sat_w;
  logic              apply_w;

  assign in_ready_o = (state_q == F_IDLE);

  assign from_w = (running_q && (fbt_q > wbt_q)) ? fbt_q : wbt_q;
  assign sum_w  = {1'b0, busy_q} + {1'b0, span_q};
  assign sat_w  = sum_w[TIME_W] ? {TIME_W{1'b1}} : sum_w[TIME_W-1:0];

  assign apply_w = (state_q == F_APPLY) &&
                   ((func_q != FUNC_WINDOW_CLOSE) || push_ready_i);

  assign push_valid_o      = (state_q == F_APPLY) && (func_q == FUNC_WINDOW_CLOSE);
  assign push_job_o.busy   = running_q ? sat_w : busy_q;
  assign push_job_o.window = window_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_SPAN;
      F_SPAN:  state_d = F_APPLY;
      F_APPLY: if (apply_w) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_e'(in_func_i);
      now_q  <= in_now_i;
    end
    if (state_q == F_SPAN) begin
      span_q   <= (now_q >= from_w) ? (now_q - from_w) : '0;
      window_q <= (now_q >= wbt_q) ? (now_q - wbt_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbt_q       <= '0;
      wbt_q       <= '0;
      busy_q      <= '0;
      running_q   <= 1'b0;
      measuring_q <= 1'b0;
    end else if (apply_w) begin
      unique case (func_q)
        FUNC_FRAME_START: begin
          fbt_q     <= now_q;
          running_q <= 1'b1;
        end
        FUNC_FRAME_END: begin
          if (measuring_q) busy_q <= sat_w;
          running_q <= 1'b0;
          fbt_q     <= '0;
        end
        FUNC_WINDOW_OPEN: begin
          busy_q      <= '0;
          wbt_q       <= now_q;
          measuring_q <= 1'b1;
        end
        FUNC_WINDOW_CLOSE: begin
          measuring_q <= 1'b0;
          if (running_q) busy_q <= sat_w;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/brm_queue.sv
`timescale 1ns / 1ps
// Job queue: small register FIFO between the front end and the ratio back end.
module brm_queue
  import brm_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  qport_t push_i,
  output logic   push_ready_o,
  output qport_t pop_o,
  input  logic   pop_ready_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign pop_o.valid  = (count_q != '0);
  assign pop_o.ready  = pop_ready_i;
  assign pop_o.job    = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && push_ready_o;
  assign do_pop  = pop_o.valid && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      if (do_push && !do_pop)      count_q <= count_q + CNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
    end
  end

endmodule

### rtl/brm_back.sv
`timescale 1ns / 1ps
// Back end: scales the busy total, divides by the window length and holds the result beat.
module brm_back
  import brm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  job_t               pop_job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RATIO_W-1:0] out_ratio_o,
  output logic [TIME_W-1:0]  out_busy_o,
  output logic [TIME_W-1:0]  out_window_o,
  output logic               out_empty_o
);

  localparam int unsigned HALF_W = TIME_W / 2;
  localparam int unsigned PROD_W = HALF_W + RATIO_W;
  localparam int unsigned DIVD_W = TIME_W + RATIO_W;
  localparam int unsigned CNT_W  = $clog2(RATIO_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RATIO_W - 1);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_ADD  = 5'b00100,
    B_DIV  = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_e;

  bstate_e            state_q, state_d;
  logic [TIME_W-1:0]  busy_q, window_q;
  logic [PROD_W-1:0]  p0_q, p1_q;
  logic               empty_q, full_q;
  logic [DIVD_W-1:0]  rem_q, div_q;
  logic [RATIO_W-1:0] quo_q;
  logic [CNT_W-1:0]   step_q;
  logic               ge_w;

  assign pop_ready_o  = (state_q == B_IDLE);
  assign out_valid_o  = (state_q == B_OUT);
  assign out_ratio_o  = quo_q;
  assign out_busy_o   = busy_q;
  assign out_window_o = window_q;
  assign out_empty_o  = empty_q;

  assign ge_w = (rem_q >= div_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (pop_valid_i) state_d = B_MUL;
      B_MUL:  state_d = B_ADD;
      B_ADD:  state_d = (empty_q || full_q) ? B_OUT : B_DIV;
      B_DIV:  if (step_q == '0) state_d = B_OUT;
      B_OUT:  if (out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          busy_q   <= pop_job_i.busy;
          window_q <= pop_job_i.window;
        end
      end
      B_MUL: begin
        p0_q    <= PROD_W'(busy_q[HALF_W-1:0]) * PROD_W'(RATIO_FULL);
        p1_q    <= PROD_W'(busy_q[TIME_W-1:HALF_W]) * PROD_W'(RATIO_FULL);
        empty_q <= (window_q == '0);
        full_q  <= (busy_q >= window_q);
      end
      B_ADD: begin
        rem_q  <= DIVD_W'(p0_q) + (DIVD_W'(p1_q) << HALF_W);
        div_q  <= DIVD_W'(window_q) << (RATIO_W - 1);
        step_q <= LAST_STEP;
        quo_q  <= empty_q ? '0 : (full_q ? RATIO_FULL : '0);
      end
      B_DIV: begin
        // restoring step: dividend is below window * 2^RATIO_W
        if (ge_w) rem_q <= rem_q - div_q;
        div_q  <= div_q >> 1;
        quo_q  <= {quo_q[RATIO_W-2:0], ge_w};
        step_q <= step_q - CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

### rtl/busy_ratio_monitor_unit.sv
`timescale 1ns / 1ps
// Top level of the busy ratio monitor: front end, job queue and ratio back end.
// Each event beat passes through the front-end sequencer (capture, span, update); no new beat
// is taken until the update is done, and a window close waits there for room in the job queue.
// Each queued job goes to the back end, which runs load, two 32x14 partial products, sum, 14
// restoring divide steps and the result beat, skips the divide when the window is empty or
// saturated, and takes no new job until the result beat is taken on m_axis_tready. The 2-entry
// job queue lets the front end keep taking frame events while a ratio is being computed.
module busy_ratio_monitor_unit
  import brm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [63:0] now_ns
  input  logic [FUNC_W-1:0]    s_axis_tuser,  // [1:0] func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [13:0] load_ratio, [77:14] busy_ns,
                                              // [141:78] window_ns, [143:142] zero
  output logic                 m_axis_tuser   // [0] window_empty
);

  qport_t             push_s, pop_s;
  logic               push_valid_s, push_ready_s, pop_ready_s;
  job_t               push_job_s;
  logic [RATIO_W-1:0] ratio_s;
  logic [TIME_W-1:0]  busy_s, window_s;

  brm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_func_i    (s_axis_tuser),
    .in_now_i     (s_axis_tdata[TIME_W-1:0]),
    .push_valid_o (push_valid_s),
    .push_ready_i (push_ready_s),
    .push_job_o   (push_job_s)
  );

  assign push_s = '{valid: push_valid_s, ready: push_ready_s, job: push_job_s};

  brm_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_s),
    .push_ready_o (push_ready_s),
    .pop_o        (pop_s),
    .pop_ready_i  (pop_ready_s)
  );

  brm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_s.valid),
    .pop_ready_o  (pop_ready_s),
    .pop_job_i    (pop_s.job),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_ratio_o  (ratio_s),
    .out_busy_o   (busy_s),
    .out_window_o (window_s),
    .out_empty_o  (m_axis_tuser)
  );

  assign m_axis_tdata = M_TDATA_W'({window_s, busy_s, ratio_s});

endmodule

### rtl/brm_checker.sv
`timescale 1ns / 1ps
// Checker: port-level properties of the busy ratio monitor, bound to the top level.
module brm_checker
  import brm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  logic [RATIO_W-1:0] ratio_c;
  logic [TIME_W-1:0]  busy_c, window_c;

  assign ratio_c  = m_axis_tdata[RATIO_W-1:0];
  assign busy_c   = m_axis_tdata[RATIO_W+TIME_W-1:RATIO_W];
  assign window_c = m_axis_tdata[RATIO_W+2*TIME_W-1:RATIO_W+TIME_W];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (window_c == '0)))
    else $error("empty flag disagrees with window length");

  a_empty_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (ratio_c == '0))
    else $error("empty window with non-zero ratio");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ratio_c <= RATIO_FULL))
    else $error("ratio above full scale");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser && (busy_c >= window_c)) |-> (ratio_c == RATIO_FULL))
    else $error("saturated window not at full scale");

endmodule

bind busy_ratio_monitor_unit brm_checker u_brm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/busy_ratio_monitor_unit_tb.sv
`timescale 1ns / 1ps
// Testbench: directed and random event streams into the busy ratio monitor, checked by a model.
module busy_ratio_monitor_unit_tb;
  import brm_pkg::*;

  localparam int unsigned RANDOM_EVENTS = 1300;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned N_ROWS        = 26;
  localparam logic [TIME_W-1:0] T_MAX   = '1;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [TIME_W-1:0]  busy;
    logic [TIME_W-1:0]  window;
    logic               empty;
  } load_report_t;

  typedef struct packed {
    func_e             func;
    logic [TIME_W-1:0] now;
    logic              typed;
    load_report_t      want;
  } stim_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [FUNC_W-1:0]    s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  busy_ratio_monitor_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predicted monitor state
  logic [TIME_W-1:0] frame_t0_ns = '0;
  logic              frame_open  = 1'b0;
  logic [TIME_W-1:0] win_t0_ns   = '0;
  logic [TIME_W-1:0] busy_sum_ns = '0;
  logic              win_open    = 1'b0;

  load_report_t      pending_reports[$];
  logic [TIME_W-1:0] clock_ns;
  bit                steady      = 1'b0;
  int unsigned       stall_left  = 0;
  int unsigned       cycle_cnt   = 0;
  int unsigned       n_events    = 0;
  int unsigned       n_results   = 0;
  int unsigned       n_empty     = 0;
  int unsigned       n_full      = 0;
  int unsigned       errors      = 0;

  stim_row_t directed_rows [N_ROWS] = '{
    '{FUNC_WINDOW_CLOSE, 64'd0,     1'b1, '{14'd0, 64'd0, 64'd0, 1'b1}},
    '{FUNC_WINDOW_OPEN,  64'd1000,  1'b0, '0},
    '{FUNC_FRAME_START,  64'd1000,  1'b0, '0},
    '{FUNC_FRAME_END,    64'd3500,  1'b0, '0},
    '{FUNC_FRAME_START,  64'd4000,  1'b0, '0},
    '{FUNC_WINDOW_CLOSE, 64'd11000, 1'b1, '{14'd9500, 64'd9500, 64'd10000, 1'b0}},
    '{FUNC_FRAME_END,    64'd12000, 1'b0, '0},
    '{FUNC_WINDOW_OPEN,  64'd20000, 1'b0, '0},
    '{FUNC_FRAME_END,    64'd25000, 1'b0, '0},
    '{FUNC_WINDOW_CLOSE, 64'd30000, 1'b1, '{14'd5000, 64'd5000, 64'd10000, 1'b0}},
    '{FUNC_FRAME_START,  64'd0,     1'b0, '0},
    '{FUNC_WINDOW_OPEN,  64'd100,   1'b0, '0},
    '{FUNC_WINDOW_CLOSE, 64'd200,   1'b1, '{RATIO_FULL, 64'd100, 64'd100, 1'b0}},
    '{FUNC_FRAME_END,    64'd50,    1'b0, '0},
    '{FUNC_WINDOW_OPEN,  64'd1000,  1'b0, '0},
    '{FUNC_FRAME_END,    64'd900,   1'b0, '0},
    '{FUNC_WINDOW_CLOSE, 64'd500,   1'b1, '{14'd0, 64'd0, 64'd0, 1'b1}},
    '{FUNC_WINDOW_OPEN,  64'd0,     1'b0, '0},
    '{FUNC_FRAME_END,    T_MAX,     1'b0, '0},
    '{FUNC_FRAME_END,    T_MAX,     1'b0, '0},
    '{FUNC_WINDOW_CLOSE, T_MAX,     1'b1, '{RATIO_FULL, T_MAX, T_MAX, 1'b0}},
    '{FUNC_WINDOW_OPEN,  64'd5,     1'b0, '0},
    '{FUNC_FRAME_START,  64'd8,     1'b0, '0},
    '{FUNC_WINDOW_OPEN,  64'd10,    1'b0, '0},
    '{FUNC_FRAME_END,    64'd13,    1'b0, '0},
    '{FUNC_WINDOW_CLOSE, 64'd17,    1'b0, '0}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] time_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TIME_W'($urandom);
      2:       return TIME_W'($urandom_range(1, 50));
      default: return TIME_W'($urandom_range(1, 5000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
  endfunction

  // span starts at the later of window start and frame start
  function automatic logic [TIME_W-1:0] busy_span(input logic [TIME_W-1:0] t,
                                                  input logic with_frame);
    logic [TIME_W-1:0] span_base;
    span_base = win_t0_ns;
    if (with_frame && frame_t0_ns > span_base) span_base = frame_t0_ns;
    return (t >= span_base) ? t - span_base : '0;
  endfunction

  function automatic logic track_event(input func_e f, input logic [TIME_W-1:0] t,
                                       output load_report_t rep);
    logic [TIME_W-1:0]   win;
    logic [2*TIME_W-1:0] scaled;
    logic                has_rep;
    rep     = '0;
    has_rep = 1'b0;
    case (f)
      FUNC_FRAME_START: begin
        frame_t0_ns = t;
        frame_open  = 1'b1;
      end
      FUNC_FRAME_END: begin
        if (win_open) busy_sum_ns = sat_sum(busy_sum_ns, busy_span(t, frame_open));
        frame_open  = 1'b0;
        frame_t0_ns = '0;
      end
      FUNC_WINDOW_OPEN: begin
        busy_sum_ns = '0;
        win_t0_ns   = t;
        win_open    = 1'b1;
      end
      default: begin
        win_open = 1'b0;
        if (frame_open) busy_sum_ns = sat_sum(busy_sum_ns, busy_span(t, 1'b1));
        win        = (t >= win_t0_ns) ? t - win_t0_ns : '0;
        rep.busy   = busy_sum_ns;
        rep.window = win;
        rep.empty  = (win == '0);
        if (win == '0) begin
          rep.ratio = '0;
        end else if (busy_sum_ns >= win) begin
          rep.ratio = RATIO_FULL;
        end else begin
          scaled    = ({{TIME_W{1'b0}}, busy_sum_ns} * (2*TIME_W)'(RATIO_FULL))
                      / {{TIME_W{1'b0}}, win};
          rep.ratio = scaled[RATIO_W-1:0];
        end
        has_rep = 1'b1;
      end
    endcase
    return has_rep;
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
    if (errors < 100)
      $display("%0t: result %0d %s: expected %0h, got %0h", $time, n_results, what, want, got);
    errors++;
  endtask

  // valid stays high across back-to-back beats; it is lowered during a random idle gap and by the caller when pausing
  task automatic send_event(input func_e f, input logic [TIME_W-1:0] t,
                            input logic typed, input load_report_t want);
    int unsigned  gap;
    load_report_t rep;
    gap = idle_cycles();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (track_event(f, t, rep)) pending_reports.push_back(typed ? want : rep);
    n_events++;
  endtask

  task automatic send_next(input func_e f);
    clock_ns = clock_ns + time_step();
    send_event(f, clock_ns, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left    <= idle_cycles();
    end
  end

  always @(posedge clk_i) begin : check_result
    load_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("beat with nothing pending", '0, '0);
      end else begin
        want = pending_reports.pop_front();
        if (want.empty) n_empty++;
        if (want.ratio == RATIO_FULL) n_full++;
        if (m_axis_tdata[13:0] !== want.ratio)
          report_mismatch("load_ratio", TIME_W'(want.ratio), TIME_W'(m_axis_tdata[13:0]));
        if (m_axis_tdata[77:14] !== want.busy)
          report_mismatch("busy_ns", want.busy, m_axis_tdata[77:14]);
        if (m_axis_tdata[141:78] !== want.window)
          report_mismatch("window_ns", want.window, m_axis_tdata[141:78]);
        if (m_axis_tdata[143:142] !== 2'b00)
          report_mismatch("tdata padding", '0, TIME_W'(m_axis_tdata[143:142]));
        if (m_axis_tuser !== want.empty)
          report_mismatch("window_empty", TIME_W'(want.empty), TIME_W'(m_axis_tuser));
      end
      n_results++;
    end
  end

  initial begin : stimulus
    int unsigned nfr;
    int unsigned nn;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_event(directed_rows[i].func, directed_rows[i].now,
                 directed_rows[i].typed, directed_rows[i].want);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);

    clock_ns = {$urandom, $urandom} >> 8;
    while (n_events < N_ROWS + RANDOM_EVENTS) begin
      steady = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 24) == 0) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_reports.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 9) < 8) begin
        // well-formed window, sometimes with a frame already running or left running
        if ($urandom_range(0, 9) == 0) clock_ns = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0) send_next(FUNC_FRAME_START);
        send_next(FUNC_WINDOW_OPEN);
        nfr = $urandom_range(0, 5);
        repeat (nfr) begin
          if ($urandom_range(0, 9) != 0) send_next(FUNC_FRAME_START);
          send_next(FUNC_FRAME_END);
        end
        if ($urandom_range(0, 3) == 0) send_next(FUNC_FRAME_START);
        send_next(FUNC_WINDOW_CLOSE);
      end else begin
        nn = $urandom_range(1, 4);
        repeat (nn) begin
          if ($urandom_range(0, 1) == 1)
            send_event(func_e'($urandom_range(0, 3)), {$urandom, $urandom}, 1'b0, '0);
          else
            send_event(func_e'($urandom_range(0, 3)),
                       clock_ns - TIME_W'($urandom_range(0, 3000)), 1'b0, '0);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d events sent, %0d window results checked (%0d empty, %0d at full load)",
             n_events, n_results, n_empty, n_full);
    $display("%0d field mismatches", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/brm_pkg.sv
rtl/brm_front.sv
rtl/brm_queue.sv
rtl/brm_back.sv
rtl/busy_ratio_monitor_unit.sv
rtl/brm_checker.sv
tb/busy_ratio_monitor_unit_tb.sv
